### hw/rtl/eirc_pkg.sv
// Shared types and constants for the Ethernet/IPv4 receive classifier.
`timescale 1ns / 1ps

package eirc_pkg;

    // Frame length limit and the widths that follow from it.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int ETH_HDR_BYTES = 14;
    localparam int IP_HDR_BYTES  = 20;
    localparam int IP_HDR_END    = ETH_HDR_BYTES + IP_HDR_BYTES;
    localparam int ETYPE_POS_HI  = 12;
    localparam int ETYPE_POS_LO  = 13;

    localparam int OFF_W       = $clog2(IP_HDR_BYTES);
    localparam int OFF_TLEN_HI = 2;
    localparam int OFF_TLEN_LO = 3;
    localparam int OFF_PROTO   = 9;
    localparam int OFF_SRC     = 12;
    localparam int OFF_DST     = 16;

    localparam int SEG_W = 11;
    localparam logic [SEG_W-1:0] SEG_MAX = '1;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] CSUM_GOOD  = 16'hFFFF;
    localparam logic [31:0] IP_BCAST   = 32'hFFFF_FFFF;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Configuration register index (paddr bit 2).
    localparam logic REG_MY_IP = 1'b0;

    typedef enum logic [3:0] {
        VERDICT_RUNT      = 4'd0,
        VERDICT_ARP       = 4'd1,
        VERDICT_UNK_TYPE  = 4'd2,
        VERDICT_SHORT_IP  = 4'd3,
        VERDICT_CSUM_ERR  = 4'd4,
        VERDICT_NOT_OURS  = 4'd5,
        VERDICT_ICMP      = 4'd6,
        VERDICT_UDP       = 4'd7,
        VERDICT_TCP       = 4'd8,
        VERDICT_OTHER     = 4'd9
    } t_verdict;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_rx_in;

    typedef struct packed {
        t_verdict         verdict;
        logic [31:0]      source_ip;
        logic [SEG_W-1:0] segment_length;
        logic [31:0]      checksum_errors;
    } t_rx_out;

endpackage

### hw/rtl/ethernet_ipv4_rx_classifier.sv
// Top level of the Ethernet/IPv4 receive header classifier.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Beat contents
// in        input      i_in_valid / o_in_stall   one frame byte plus last-byte mark
// out       output     o_out_valid / i_out_stall one verdict per frame
// config    input      APB (psel, penable, ...)  my_ip at byte address 0
//
// Each byte is held in the input register and folded into the frame state
// as it leaves, so the block takes one byte per cycle while the input is
// not stalled. The final byte of a frame writes the verdict into the
// output register as it leaves the input register. The input stalls only
// when a final byte sits there and the output register is full and stalled.
// Reset is synchronous and active low; it clears all frame state, the
// checksum error count and my_ip.

module ethernet_ipv4_rx_classifier (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  eirc_pkg::t_rx_in i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output eirc_pkg::t_rx_out o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import eirc_pkg::*;

    // Input register.
    logic       r_in_valid;
    t_rx_in     r_in;

    // Frame state, updated as each byte leaves the input register.
    logic [CNT_W-1:0] r_count,  n_count;
    logic [15:0]      r_sum,    n_sum;
    logic [7:0]       r_hold,   n_hold;
    logic [15:0]      r_etype,  n_etype;
    logic [31:0]      r_src,    n_src;
    logic [31:0]      r_dst,    n_dst;
    logic [7:0]       r_proto,  n_proto;
    logic [15:0]      r_tlen,   n_tlen;
    logic [31:0]      r_errs,   n_errs;
    logic [31:0]      r_my_ip;

    // Output register.
    logic    r_out_valid;
    t_rx_out r_out;

    logic             out_free;
    logic             consume;
    logic             accept;
    logic             take;
    logic             in_ip_hdr;
    logic [OFF_W-1:0] off;
    logic [16:0]      sum_wide;
    logic [15:0]      iplen;
    logic [15:0]      plen;
    logic [15:0]      seg_full;
    logic [SEG_W-1:0] seg;
    t_verdict         verdict;
    logic             dst_ok;

    // The byte in the input register moves on unless it closes a frame and
    // the output register cannot take the verdict.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign consume    = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_valid && !consume;
    assign accept     = i_in_valid && !o_in_stall;

    // Configuration port: zero wait states, one register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MY_IP) ? r_my_ip : 32'd0;

    // Byte position decode. Bytes past the length limit are dropped.
    assign take      = r_count < CNT_W'(MAX_FRAME_BYTES);
    assign in_ip_hdr = take && (r_count >= CNT_W'(ETH_HDR_BYTES))
                            && (r_count <  CNT_W'(IP_HDR_END));
    assign off       = OFF_W'(r_count - CNT_W'(ETH_HDR_BYTES));
    assign sum_wide  = {1'b0, r_sum} + {1'b0, r_hold, r_in.frame_byte};

    always_comb begin
        n_count = take ? r_count + CNT_W'(1) : r_count;
        n_sum   = r_sum;
        n_hold  = r_hold;
        n_etype = r_etype;
        n_src   = r_src;
        n_dst   = r_dst;
        n_proto = r_proto;
        n_tlen  = r_tlen;
        if (take && (r_count == CNT_W'(ETYPE_POS_HI) || r_count == CNT_W'(ETYPE_POS_LO))) begin
            n_etype = {r_etype[7:0], r_in.frame_byte};
        end
        if (in_ip_hdr) begin
            // Ones-complement sum over 16-bit words with end-around carry.
            if (!off[0]) begin
                n_hold = r_in.frame_byte;
            end else begin
                n_sum = sum_wide[15:0] + 16'(sum_wide[16]);
            end
            if (off == OFF_W'(OFF_TLEN_HI) || off == OFF_W'(OFF_TLEN_LO)) begin
                n_tlen = {r_tlen[7:0], r_in.frame_byte};
            end
            if (off == OFF_W'(OFF_PROTO)) begin
                n_proto = r_in.frame_byte;
            end
            if (off >= OFF_W'(OFF_SRC) && off < OFF_W'(OFF_DST)) begin
                n_src = {r_src[23:0], r_in.frame_byte};
            end
            if (off >= OFF_W'(OFF_DST)) begin
                n_dst = {r_dst[23:0], r_in.frame_byte};
            end
        end
    end

    // Classification works on the state that includes the current byte.
    assign dst_ok   = (n_dst == r_my_ip) || (n_dst == IP_BCAST);
    assign iplen    = 16'(n_count) - 16'(ETH_HDR_BYTES);
    assign plen     = (n_tlen > iplen) ? iplen : n_tlen;
    assign seg_full = plen - 16'(IP_HDR_BYTES);
    assign seg      = (plen < 16'(IP_HDR_BYTES)) ? '0 :
                      (seg_full > 16'(SEG_MAX)) ? SEG_MAX : seg_full[SEG_W-1:0];

    always_comb begin
        n_errs = r_errs;
        if (n_count < CNT_W'(ETH_HDR_BYTES)) begin
            verdict = VERDICT_RUNT;
        end else if (n_etype == ETYPE_ARP) begin
            verdict = VERDICT_ARP;
        end else if (n_etype != ETYPE_IPV4) begin
            verdict = VERDICT_UNK_TYPE;
        end else if (n_count < CNT_W'(IP_HDR_END)) begin
            verdict = VERDICT_SHORT_IP;
        end else if (n_sum != CSUM_GOOD) begin
            verdict = VERDICT_CSUM_ERR;
            n_errs  = r_errs + 32'd1;
        end else if (!dst_ok) begin
            verdict = VERDICT_NOT_OURS;
        end else begin
            case (n_proto)
                PROTO_ICMP: verdict = VERDICT_ICMP;
                PROTO_UDP:  verdict = VERDICT_UDP;
                PROTO_TCP:  verdict = VERDICT_TCP;
                default:    verdict = VERDICT_OTHER;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_hold      <= '0;
            r_etype     <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_proto     <= '0;
            r_tlen      <= '0;
            r_errs      <= '0;
            r_my_ip     <= '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_MY_IP) begin
                r_my_ip <= pwdata;
            end

            if (accept) begin
                r_in_valid <= 1'b1;
                r_in       <= i_in_data;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end

            if (consume && r_in.last_byte) begin
                // Frame closes: publish the verdict and restart frame state.
                r_out_valid <= 1'b1;
                r_out.verdict         <= verdict;
                r_out.source_ip       <= (verdict >= VERDICT_ICMP) ? n_src : 32'd0;
                r_out.segment_length  <= (verdict >= VERDICT_ICMP) ? seg : '0;
                r_out.checksum_errors <= n_errs;
                r_errs  <= n_errs;
                r_count <= '0;
                r_sum   <= '0;
                r_hold  <= '0;
                r_etype <= '0;
                r_src   <= '0;
                r_dst   <= '0;
                r_proto <= '0;
                r_tlen  <= '0;
            end else begin
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
                if (consume) begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_hold  <= n_hold;
                    r_etype <= n_etype;
                    r_src   <= n_src;
                    r_dst   <= n_dst;
                    r_proto <= n_proto;
                    r_tlen  <= n_tlen;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/eirc_checker.sv
// Port-level assertions for the receive classifier, bound to the top level.
`timescale 1ns / 1ps

module eirc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input eirc_pkg::t_rx_out o_out_data
);
    import eirc_pkg::*;

    // A stalled verdict beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Address and length are only reported for frames handed to a protocol.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.verdict < VERDICT_ICMP |->
            o_out_data.source_ip == 32'd0 && o_out_data.segment_length == '0)
        else $error("address or length on a rejected frame");

    // A checksum failure is always included in the running count.
    a_csum_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.verdict == VERDICT_CSUM_ERR |->
            o_out_data.checksum_errors != 32'd0)
        else $error("checksum failure not counted");

endmodule

bind ethernet_ipv4_rx_classifier eirc_checker u_eirc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/tb.sv
// Self-checking testbench for the Ethernet/IPv4 receive classifier.
`timescale 1ns / 1ps

module tb;
    import eirc_pkg::*;

    // Run length guard, settle time after the last verdict, and the length of
    // the long receiver hold-off that makes the block back up into its input.
    localparam int RUN_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_BEATS   = 290;
    localparam int N_DIRECTED    = 18;
    localparam int N_PHASES      = 5;

    // Local address used throughout the directed frames.
    localparam logic [31:0] DIR_IP = 32'hC0A8_0105;

    // One frame to be sent. The header fields are only placed in the frame
    // as far as its length reaches. When pinned is set, the verdict in want
    // is what the block must give; otherwise the verdict comes from the
    // frame tracker below.
    typedef struct packed {
        logic [11:0] len;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [15:0] tot_len;
        logic [31:0] src;
        logic [31:0] dst;
        logic        csum_ok;
        logic        pinned;
        t_rx_out     want;
    } t_frame_spec;

    typedef struct packed {
        logic    pinned;
        t_rx_out want;
    } t_pin;

    // Directed frames: runts, ARP, foreign ethertypes, short IPv4 headers,
    // bad checksums, a foreign destination, broadcast, every protocol, the
    // total-length clamp and repair, and one frame past the byte-count limit.
    localparam t_frame_spec DIRECTED [N_DIRECTED] = '{
        '{12'd1,    16'h0000,   8'h00,      16'd0,     32'h0,         32'h0,
          1'b1, 1'b1, '{VERDICT_RUNT, 32'h0, 11'd0, 32'd0}},
        // Runt whose one ethertype byte already reads as IPv4.
        '{12'd13,   ETYPE_IPV4, 8'h00,      16'd0,     32'h0,         32'h0,
          1'b1, 1'b1, '{VERDICT_RUNT, 32'h0, 11'd0, 32'd0}},
        '{12'd14,   ETYPE_ARP,  8'h00,      16'd0,     32'h0,         32'h0,
          1'b1, 1'b1, '{VERDICT_ARP, 32'h0, 11'd0, 32'd0}},
        '{12'd60,   ETYPE_ARP,  8'h00,      16'd0,     32'h0,         32'h0,
          1'b1, 1'b1, '{VERDICT_ARP, 32'h0, 11'd0, 32'd0}},
        '{12'd14,   16'h86DD,   8'h00,      16'd0,     32'h0,         32'h0,
          1'b1, 1'b1, '{VERDICT_UNK_TYPE, 32'h0, 11'd0, 32'd0}},
        '{12'd14,   ETYPE_IPV4, 8'h00,      16'd0,     32'h0,         32'h0,
          1'b1, 1'b1, '{VERDICT_SHORT_IP, 32'h0, 11'd0, 32'd0}},
        // One byte short of a full IPv4 header.
        '{12'd33,   ETYPE_IPV4, PROTO_UDP,  16'd20,    32'h0A00_0001, DIR_IP,
          1'b1, 1'b1, '{VERDICT_SHORT_IP, 32'h0, 11'd0, 32'd0}},
        // Exactly a full header and nothing after it.
        '{12'd34,   ETYPE_IPV4, PROTO_ICMP, 16'd20,    32'h0A00_0001, DIR_IP,
          1'b1, 1'b1, '{VERDICT_ICMP, 32'h0A00_0001, 11'd0, 32'd0}},
        '{12'd60,   ETYPE_IPV4, PROTO_UDP,  16'd46,    32'h0A00_0002, DIR_IP,
          1'b0, 1'b1, '{VERDICT_CSUM_ERR, 32'h0, 11'd0, 32'd1}},
        '{12'd60,   ETYPE_IPV4, PROTO_TCP,  16'd46,    32'h0A00_0003, 32'h0A00_00FF,
          1'b1, 1'b1, '{VERDICT_NOT_OURS, 32'h0, 11'd0, 32'd1}},
        '{12'd60,   ETYPE_IPV4, PROTO_UDP,  16'd46,    32'hC0A8_0001, IP_BCAST,
          1'b1, 1'b1, '{VERDICT_UDP, 32'hC0A8_0001, 11'd26, 32'd1}},
        // Total length far beyond what arrived: clamped to the received bytes.
        '{12'd60,   ETYPE_IPV4, PROTO_TCP,  16'hFFFF,  32'h0A00_0004, DIR_IP,
          1'b1, 1'b0, '0},
        // Total length under a header's worth: segment length repaired to zero.
        '{12'd60,   ETYPE_IPV4, 8'hFF,      16'd10,    32'h0102_0304, DIR_IP,
          1'b1, 1'b1, '{VERDICT_OTHER, 32'h0102_0304, 11'd0, 32'd1}},
        '{12'd60,   ETYPE_IPV4, 8'h00,      16'd40,    32'h0A00_0005, DIR_IP,
          1'b1, 1'b0, '0},
        // Longer than the byte counter goes: it saturates and the length
        // reported is taken from the saturated count.
        '{12'd2060, ETYPE_IPV4, PROTO_UDP,  16'hFFFF,  32'h0A0A_0A0A, DIR_IP,
          1'b1, 1'b1, '{VERDICT_UDP, 32'h0A0A_0A0A, 11'd2014, 32'd1}},
        '{12'd80,   ETYPE_IPV4, PROTO_TCP,  16'd66,    32'hFFFF_FFFF, DIR_IP,
          1'b0, 1'b0, '0},
        '{12'd34,   ETYPE_IPV4, PROTO_ICMP, 16'd0,     32'hFFFF_FFFF, IP_BCAST,
          1'b1, 1'b0, '0},
        '{12'd48,   16'hFFFF,   8'h00,      16'd0,     32'h0,         32'h0,
          1'b1, 1'b1, '{VERDICT_UNK_TYPE, 32'h0, 11'd0, 32'd2}}
    };

    logic    i_clk;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    o_in_stall;
    t_rx_in  i_in_data   = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_rx_out o_out_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    ethernet_ipv4_rx_classifier DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Frame tracker state: the testbench's own copy of what the block keeps
    // between bytes, plus the register it compares destinations against.
    logic [CNT_W-1:0] rx_count      = '0;
    logic [15:0]      hdr_sum       = '0;
    logic [7:0]       hi_hold       = '0;
    logic [15:0]      etype_seen    = '0;
    logic [31:0]      ip_src        = '0;
    logic [31:0]      ip_dst        = '0;
    logic [7:0]       ip_proto      = '0;
    logic [15:0]      ip_tot_len    = '0;
    logic [31:0]      bad_sum_total = '0;
    logic [31:0]      cfg_local_ip  = '0;

    t_rx_out verdicts_due [$];
    t_pin    pin_q [$];

    // Run bookkeeping. idle_on lets both sides insert gaps; hold_asks is
    // raised by the stimulus whenever it wants a long receiver hold-off.
    bit idle_on         = 1'b1;
    int hold_asks       = 0;
    int mismatches      = 0;
    int beats_sent      = 0;
    int frames_sent     = 0;
    int results_checked = 0;
    int ip_settings     = 0;
    int cycle_count     = 0;
    int verdict_hits [16];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Folds one accepted byte into the tracker state. On the final byte of a
    // frame it works out the verdict and clears the per-frame state.
    task automatic fold_frame_byte(input t_rx_in beat, output logic done,
                                   output t_rx_out res);
        int          pos;
        int          off;
        int          ip_bytes;
        int          plen;
        int          seg;
        logic [16:0] acc;
        done = 1'b0;
        res  = '0;
        if (rx_count < MAX_FRAME_BYTES) begin
            pos = int'(rx_count);
            if (pos == ETYPE_POS_HI || pos == ETYPE_POS_LO)
                etype_seen = {etype_seen[7:0], beat.frame_byte};
            if (pos >= ETH_HDR_BYTES && pos < IP_HDR_END) begin
                off = pos - ETH_HDR_BYTES;
                // Header words are summed with the carry wrapped back in.
                if (off % 2 == 0) begin
                    hi_hold = beat.frame_byte;
                end else begin
                    acc     = hdr_sum + {hi_hold, beat.frame_byte};
                    hdr_sum = acc[15:0] + acc[16];
                end
                if (off == OFF_TLEN_HI || off == OFF_TLEN_LO)
                    ip_tot_len = {ip_tot_len[7:0], beat.frame_byte};
                if (off == OFF_PROTO)
                    ip_proto = beat.frame_byte;
                if (off >= OFF_SRC && off < OFF_DST)
                    ip_src = {ip_src[23:0], beat.frame_byte};
                if (off >= OFF_DST && off < IP_HDR_BYTES)
                    ip_dst = {ip_dst[23:0], beat.frame_byte};
            end
            rx_count = rx_count + 1'b1;
        end
        if (beat.last_byte) begin
            done     = 1'b1;
            ip_bytes = int'(rx_count) - ETH_HDR_BYTES;
            if (rx_count < ETH_HDR_BYTES) begin
                res.verdict = VERDICT_RUNT;
            end else if (etype_seen == ETYPE_ARP) begin
                res.verdict = VERDICT_ARP;
            end else if (etype_seen != ETYPE_IPV4) begin
                res.verdict = VERDICT_UNK_TYPE;
            end else if (ip_bytes < IP_HDR_BYTES) begin
                res.verdict = VERDICT_SHORT_IP;
            end else if (hdr_sum != CSUM_GOOD) begin
                bad_sum_total++;
                res.verdict = VERDICT_CSUM_ERR;
            end else if (ip_dst != cfg_local_ip && ip_dst != IP_BCAST) begin
                res.verdict = VERDICT_NOT_OURS;
            end else begin
                plen = (int'(ip_tot_len) > ip_bytes) ? ip_bytes : int'(ip_tot_len);
                seg  = (plen < IP_HDR_BYTES) ? 0 : plen - IP_HDR_BYTES;
                if (seg > int'(SEG_MAX))
                    seg = int'(SEG_MAX);
                res.source_ip      = ip_src;
                res.segment_length = seg[SEG_W-1:0];
                case (ip_proto)
                    PROTO_ICMP: res.verdict = VERDICT_ICMP;
                    PROTO_UDP:  res.verdict = VERDICT_UDP;
                    PROTO_TCP:  res.verdict = VERDICT_TCP;
                    default:    res.verdict = VERDICT_OTHER;
                endcase
            end
            res.checksum_errors = bad_sum_total;
            rx_count   = '0;
            hdr_sum    = '0;
            hi_hold    = '0;
            etype_seen = '0;
            ip_src     = '0;
            ip_dst     = '0;
            ip_proto   = '0;
            ip_tot_len = '0;
        end
    endtask

    // Offers one beat and returns at the edge that takes it.
    task automatic put_beat(input t_rx_in beat);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
    endtask

    task automatic sender_pause();
        int n;
        n = idle_on ? gap_len() : 0;
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Builds the frame around a 20-byte IPv4 header and sends it. The header
    // checksum is made right, or wrong by exactly one bit, which can never
    // sum to the good value again.
    task automatic send_frame(input t_frame_spec f);
        logic [7:0]  hdr [IP_HDR_BYTES];
        logic [16:0] acc;
        logic [15:0] hsum;
        logic [7:0]  b;
        int          i;
        for (i = 0; i < IP_HDR_BYTES; i++)
            hdr[i] = 8'($urandom());
        {hdr[2], hdr[3]} = f.tot_len;
        hdr[9]           = f.proto;
        {hdr[10], hdr[11]} = 16'h0000;
        {hdr[12], hdr[13], hdr[14], hdr[15]} = f.src;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = f.dst;
        hsum = '0;
        for (i = 0; i < IP_HDR_BYTES; i += 2) begin
            acc  = hsum + {hdr[i], hdr[i+1]};
            hsum = acc[15:0] + acc[16];
        end
        hsum = ~hsum;
        if (!f.csum_ok)
            hsum = hsum ^ (16'h0001 << $urandom_range(0, 15));
        {hdr[10], hdr[11]} = hsum;
        pin_q.push_back(t_pin'{f.pinned, f.want});
        for (i = 0; i < int'(f.len); i++) begin
            if (i == ETYPE_POS_HI)
                b = f.etype[15:8];
            else if (i == ETYPE_POS_LO)
                b = f.etype[7:0];
            else if (i >= ETH_HDR_BYTES && i < IP_HDR_END)
                b = hdr[i-ETH_HDR_BYTES];
            else
                b = 8'($urandom());
            put_beat(t_rx_in'{b, (i == int'(f.len) - 1)});
            sender_pause();
        end
        frames_sent++;
    endtask

    // Random frames are mostly well-formed IPv4 with random content, so
    // they get past the ethertype and length checks; the rest are runts,
    // ARP, foreign ethertypes and truncated headers.
    function automatic t_frame_spec random_frame();
        t_frame_spec f;
        int          shape;
        int          pick;
        f         = '0;
        f.src     = $urandom();
        f.csum_ok = ($urandom_range(0, 99) < 80);
        shape     = $urandom_range(0, 99);
        if (shape < 8) begin
            f.len   = 12'($urandom_range(1, ETH_HDR_BYTES - 1));
            f.etype = 16'($urandom());
        end else if (shape < 16) begin
            f.len   = 12'($urandom_range(ETH_HDR_BYTES, 48));
            f.etype = (shape < 11) ? ETYPE_ARP : 16'($urandom());
        end else begin
            f.etype = ETYPE_IPV4;
            if (shape < 22)
                f.len = 12'($urandom_range(ETH_HDR_BYTES, IP_HDR_END - 1));
            else if (shape < 25)
                f.len = 12'($urandom_range(100, 300));
            else
                f.len = 12'($urandom_range(IP_HDR_END, 64));
        end
        pick = $urandom_range(0, 99);
        if (pick < 25)
            f.proto = PROTO_ICMP;
        else if (pick < 50)
            f.proto = PROTO_UDP;
        else if (pick < 75)
            f.proto = PROTO_TCP;
        else
            f.proto = 8'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 50)
            f.tot_len = 16'(f.len - ETH_HDR_BYTES);
        else if (pick < 70)
            f.tot_len = 16'($urandom_range(0, int'(f.len)));
        else if (pick < 85)
            f.tot_len = 16'($urandom_range(0, 25));
        else
            f.tot_len = 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 45)
            f.dst = cfg_local_ip;
        else if (pick < 60)
            f.dst = IP_BCAST;
        else if (pick < 70)
            f.dst = cfg_local_ip ^ (32'h1 << $urandom_range(0, 31));
        else
            f.dst = $urandom();
        return f;
    endfunction

    // Writes my_ip with an APB setup and access phase, then reads it back.
    task automatic set_local_ip(input logic [31:0] ip);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MY_IP, 2'b00};
        pwdata  <= ip;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== ip)
            flag_error($sformatf("my_ip read back %h, wrote %h", prdata, ip));
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_local_ip = ip;
        ip_settings++;
    endtask

    // Lets every expected verdict come out, then waits out the settle time so
    // the block has nothing left in flight.
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Watches both channels at each edge. An accepted input beat goes into
    // the tracker; the final beat of a frame queues its expected verdict.
    // An accepted output beat is checked against the oldest one queued.
    always @(posedge i_clk) begin : watch
        logic    ends_frame;
        t_rx_out guess;
        t_pin    pin;
        t_rx_out want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                fold_frame_byte(i_in_data, ends_frame, guess);
                if (ends_frame) begin
                    pin = pin_q.pop_front();
                    verdicts_due.push_back(pin.pinned ? pin.want : guess);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    flag_error($sformatf("verdict %0d with none expected",
                                         o_out_data.verdict));
                end else begin
                    want = verdicts_due.pop_front();
                    results_checked++;
                    verdict_hits[want.verdict]++;
                    if (o_out_data.verdict !== want.verdict)
                        flag_error($sformatf("verdict %0d, expected %0d",
                                             o_out_data.verdict, want.verdict));
                    if (o_out_data.source_ip !== want.source_ip)
                        flag_error($sformatf("source_ip %h, expected %h",
                                             o_out_data.source_ip, want.source_ip));
                    if (o_out_data.segment_length !== want.segment_length)
                        flag_error($sformatf("segment_length %0d, expected %0d",
                                             o_out_data.segment_length,
                                             want.segment_length));
                    if (o_out_data.checksum_errors !== want.checksum_errors)
                        flag_error($sformatf("checksum_errors %0d, expected %0d",
                                             o_out_data.checksum_errors,
                                             want.checksum_errors));
                end
            end
        end
    end

    // Receiver side. A hold-off request stalls the output for a long fixed
    // stretch while the sender keeps going, so the block fills and stalls
    // its input. Otherwise the stall comes and goes at random while idling
    // is enabled.
    initial begin : out_side
        int stall_left;
        int hold_left;
        int holds_done;
        stall_left = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done < hold_asks) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (stall_left == 0 && idle_on)
                    stall_left = gap_len();
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus: reset, the directed frames under a fixed local address, then
    // random frames under a series of local addresses that includes both
    // extremes. Each new address starts with a long receiver hold-off.
    initial begin : stimulus
        logic [31:0] ip_plan [N_PHASES];
        int          k;
        int          p;
        int          phase_end;
        ip_plan[0] = 32'h0000_0000;
        ip_plan[1] = 32'hFFFF_FFFF;
        ip_plan[2] = $urandom();
        ip_plan[3] = 32'h7F00_0001;
        ip_plan[4] = $urandom();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_local_ip(DIR_IP);
        for (k = 0; k < N_DIRECTED; k++)
            send_frame(DIRECTED[k]);

        for (p = 0; p < N_PHASES; p++) begin
            wait_for_idle();
            set_local_ip(ip_plan[p]);
            hold_asks++;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                // Now and then switch idling off for a stretch of frames.
                if ($urandom_range(0, 7) == 0)
                    idle_on = !idle_on;
                send_frame(random_frame());
            end
        end

        wait_for_idle();
        $display("Checked %0d verdicts from %0d frames (%0d bytes) under %0d addresses.",
                 results_checked, frames_sent, beats_sent, ip_settings);
        $display({"Verdicts runt/arp/type/short/csum/foreign/icmp/udp/tcp/other:",
                  " %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d"},
                 verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
                 verdict_hits[4], verdict_hits[5], verdict_hits[6], verdict_hits[7],
                 verdict_hits[8], verdict_hits[9]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hw/rtl/eirc_pkg.sv
hw/rtl/ethernet_ipv4_rx_classifier.sv
hw/rtl/eirc_checker.sv
tb/tb.sv
